FILE: rtl/lurt_pkg.sv
// ----------------------------------------------------------------------------
// lurt_pkg
// Shared constants and types for the longest unique run tracker.
// ----------------------------------------------------------------------------
package lurt_pkg;

    localparam int SYMBOL_W  = 8;
    localparam int LONGEST_W = 17;

    localparam logic [LONGEST_W-1:0] LONGEST_MAX = {LONGEST_W{1'b1}};

    // per-cycle control from the handshake logic to the window datapath
    typedef struct packed {
        logic accept;
        logic fire;
        logic last;
    } step_ctl_t;

endpackage

FILE: rtl/lurt_sym_map.sv
// ----------------------------------------------------------------------------
// lurt_sym_map
// Folds an input byte into the alphabet range with a constant lookup table.
// ----------------------------------------------------------------------------
module lurt_sym_map #(
    parameter int ALPHABET = 256,
    parameter int IDX_W    = 8
) (
    input  logic [lurt_pkg::SYMBOL_W-1:0] symbol,
    output logic [IDX_W-1:0]              idx
);

    localparam int NUM_CODES = 2 ** lurt_pkg::SYMBOL_W;

    logic [IDX_W-1:0] fold_tab [NUM_CODES];

    for (genvar i = 0; i < NUM_CODES; i++) begin : g_tab
        localparam int FOLDED = i % ALPHABET;
        assign fold_tab[i] = IDX_W'(FOLDED);
    end

    assign idx = fold_tab[symbol];

endmodule

FILE: rtl/lurt_seen_mem.sv
// ----------------------------------------------------------------------------
// lurt_seen_mem
// Last-seen position memory: synchronous read, one write port, and a bypass
// for a write that lands on the same edge as the read of the same entry.
// ----------------------------------------------------------------------------
module lurt_seen_mem #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8,
    parameter int LSP_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [LSP_W-1:0] wr_pos,
    output logic [LSP_W-1:0] lsp
);

    logic [LSP_W-1:0] pos_mem [DEPTH];
    logic [LSP_W-1:0] rd_data_reg;
    logic [LSP_W-1:0] byp_pos_reg;
    logic             byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_idx] <= wr_pos;
        end
        if (accept)
        begin
            rd_data_reg <= pos_mem[rd_idx];
            byp_pos_reg <= wr_pos;
        end
    end

    // the read on this edge sees the old entry, so remember the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            byp_hit_reg <= wr_en && (wr_idx == rd_idx);
        end
    end

    assign lsp = byp_hit_reg ? byp_pos_reg : rd_data_reg;

endmodule

FILE: rtl/lurt_window.sv
// ----------------------------------------------------------------------------
// lurt_window
// Window start, position, best length and seen bits; computes the run length
// of the byte in the processing stage and issues the memory write.
// ----------------------------------------------------------------------------
module lurt_window #(
    parameter int MAX_LEN = 65536,
    parameter int DEPTH   = 256,
    parameter int IDX_W   = 8,
    parameter int POS_W   = 17,
    parameter int LSP_W   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lurt_pkg::step_ctl_t              ctl,
    input  logic [IDX_W-1:0]                 idx,
    input  logic [LSP_W-1:0]                 lsp,
    output logic                             wr_en,
    output logic [LSP_W-1:0]                 wr_pos,
    output logic [lurt_pkg::LONGEST_W-1:0]   longest,
    output logic                             too_long
);

    localparam int EXT_W = (POS_W > lurt_pkg::LONGEST_W) ? POS_W : lurt_pkg::LONGEST_W;

    logic [DEPTH-1:0] seen_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] best_reg;
    logic             ovf_reg;

    logic             at_limit;
    logic [POS_W-1:0] lsp_ext;
    logic             repeat_hit;
    logic [POS_W-1:0] start_next;
    logic [POS_W-1:0] run_len;
    logic [POS_W-1:0] best_next;
    logic [EXT_W-1:0] best_ext;

    always_comb
    begin
        at_limit   = pos_reg >= POS_W'(MAX_LEN);
        lsp_ext    = POS_W'(lsp);
        repeat_hit = seen_reg[idx] && (lsp_ext >= start_reg);
        start_next = repeat_hit ? (lsp_ext + POS_W'(1)) : start_reg;
        run_len    = pos_reg - start_next + POS_W'(1);
        if (at_limit)
        begin
            best_next = best_reg;
        end
        else
        begin
            best_next = (run_len > best_reg) ? run_len : best_reg;
        end
        best_ext = EXT_W'(best_next);
    end

    assign wr_en    = ctl.fire && !at_limit;
    assign wr_pos   = pos_reg[LSP_W-1:0];
    assign too_long = ovf_reg || at_limit;
    assign longest  = (best_ext > EXT_W'(lurt_pkg::LONGEST_MAX)) ? lurt_pkg::LONGEST_MAX
                                                                  : best_ext[lurt_pkg::LONGEST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (ctl.fire)
        begin
            if (ctl.last)
            begin
                // string closed: start over
                seen_reg  <= '0;
                start_reg <= '0;
                pos_reg   <= '0;
                best_reg  <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (at_limit)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                seen_reg[idx] <= 1'b1;
                start_reg     <= start_next;
                pos_reg       <= pos_reg + POS_W'(1);
                best_reg      <= best_next;
            end
        end
    end

endmodule

FILE: rtl/longest_unique_run_tracker.sv
// ----------------------------------------------------------------------------
// longest_unique_run_tracker
// Streams bytes of a string and reports, for every byte, the longest run of
// distinct bytes seen so far in that string. Takes one byte every clock cycle
// while the result is not stalled. Each byte waits in the processing stage
// register, and its result is then registered in the result register.
// On the transfer edge the byte is folded into the alphabet and its last-seen
// position is read from a synchronous memory; in the processing stage that
// position is compared with the window start, the window and best length are
// updated and the new position is written back. A write and a read of the
// same entry on one edge are bypassed, so repeated bytes stream at full rate.
// The result register lets one new byte enter while a result waits; after that
// the input stalls until the result is taken. The byte flagged last_symbol
// closes the string and all per-string state clears at once. Bytes beyond
// MAX_LEN are ignored and too_long stays high until the string ends.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker #(
    parameter int MAX_LEN  = 65536,
    parameter int ALPHABET = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [lurt_pkg::SYMBOL_W-1:0]       symbol,
    input  logic                                last_symbol,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [lurt_pkg::LONGEST_W-1:0]      longest_so_far,
    output logic                                string_end,
    output logic                                too_long
);

    localparam int NUM_CODES = 2 ** lurt_pkg::SYMBOL_W;
    localparam int DEPTH     = (ALPHABET < NUM_CODES) ? ALPHABET : NUM_CODES;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int LSP_W     = $clog2(MAX_LEN);

    logic [IDX_W-1:0]                 sym_idx;
    logic                             s1_valid_reg;
    logic [IDX_W-1:0]                 s1_idx_reg;
    logic                             s1_last_reg;
    logic                             s1_fire;
    logic                             item_accept;
    lurt_pkg::step_ctl_t              ctl;
    logic                             wr_en;
    logic [LSP_W-1:0]                 wr_pos;
    logic [LSP_W-1:0]                 lsp;
    logic [lurt_pkg::LONGEST_W-1:0]   longest_next;
    logic                             too_long_next;

    logic                             result_valid_reg;
    logic [lurt_pkg::LONGEST_W-1:0]   longest_reg;
    logic                             string_end_reg;
    logic                             too_long_reg;

    assign s1_fire     = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = s1_valid_reg && !s1_fire;
    assign item_accept = item_valid && !item_stall;

    assign ctl.accept = item_accept;
    assign ctl.fire   = s1_fire;
    assign ctl.last   = s1_last_reg;

    lurt_sym_map #(
        .ALPHABET (ALPHABET),
        .IDX_W    (IDX_W)
    ) u_sym_map (
        .symbol (symbol),
        .idx    (sym_idx)
    );

    lurt_seen_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .LSP_W (LSP_W)
    ) u_seen_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (ctl.accept),
        .rd_idx (sym_idx),
        .wr_en  (wr_en),
        .wr_idx (s1_idx_reg),
        .wr_pos (wr_pos),
        .lsp    (lsp)
    );

    lurt_window #(
        .MAX_LEN (MAX_LEN),
        .DEPTH   (DEPTH),
        .IDX_W   (IDX_W),
        .POS_W   (POS_W),
        .LSP_W   (LSP_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .idx      (s1_idx_reg),
        .lsp      (lsp),
        .wr_en    (wr_en),
        .wr_pos   (wr_pos),
        .longest  (longest_next),
        .too_long (too_long_next)
    );

    // processing stage and result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_idx_reg  <= sym_idx;
            s1_last_reg <= last_symbol;
        end
        if (s1_fire)
        begin
            longest_reg    <= longest_next;
            string_end_reg <= s1_last_reg;
            too_long_reg   <= too_long_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign longest_so_far = longest_reg;
    assign string_end     = string_end_reg;
    assign too_long       = too_long_reg;

    // a byte is held back only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid_reg && result_stall))
        else $error("input stalled without a blocked result");

    // the closing byte yields a closing result
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (result_valid && string_end))
        else $error("string end lost");

    // any counted byte gives a run of at least one
    a_nonzero_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !too_long) |-> (longest_so_far != '0))
        else $error("zero run length on a counted byte");

    // a result that waits keeps its slot until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("waiting result dropped");

endmodule

FILE: tb/tb_longest_unique_run_tracker.sv
// ----------------------------------------------------------------------------
// tb_longest_unique_run_tracker
// Feeds byte strings through the tracker and checks every result against a
// local model of the distinct-run window or, for flagged directed bytes,
// against the table's values. A short table of directed bytes comes first,
// then random strings under three idle mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_longest_unique_run_tracker;

    localparam int MAX_LEN        = 65536;
    localparam int HOLD_CYCLES    = 200;
    localparam int TIMEOUT_CYCLES = 600000;

    typedef struct packed {
        logic [lurt_pkg::LONGEST_W-1:0] longest;
        logic                           string_end;
        logic                           too_long;
    } run_result_t;

    typedef struct packed {
        logic [lurt_pkg::SYMBOL_W-1:0]  sym;
        logic                           last;
        logic                           typed;
        logic [lurt_pkg::LONGEST_W-1:0] want_len;
        logic                           want_too_long;
    } stim_row_t;

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           item_valid     = 1'b0;
    logic [lurt_pkg::SYMBOL_W-1:0]  symbol         = '0;
    logic                           last_symbol    = 1'b0;
    logic                           result_stall   = 1'b0;
    logic                           item_stall;
    logic                           result_valid;
    logic [lurt_pkg::LONGEST_W-1:0] longest_so_far;
    logic                           string_end;
    logic                           too_long;

    // model of the per-string window state
    bit [15:0]                    pos_of_sym [256];
    bit                           sym_seen   [256];
    bit [lurt_pkg::LONGEST_W-1:0] win_start;
    bit [lurt_pkg::LONGEST_W-1:0] str_pos;
    bit [lurt_pkg::LONGEST_W-1:0] best_run;
    bit                           over_limit;

    run_result_t pending_runs [$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;

    stim_row_t directed_rows [0:20];

    longest_unique_run_tracker #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (256)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .symbol         (symbol),
        .last_symbol    (last_symbol),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .longest_so_far (longest_so_far),
        .string_end     (string_end),
        .too_long       (too_long)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic run_result_t advance_run_state(
        input logic [lurt_pkg::SYMBOL_W-1:0] sym,
        input logic last);
        run_result_t                  r;
        bit [lurt_pkg::LONGEST_W-1:0] run_len;
        if (str_pos >= MAX_LEN)
        begin
            over_limit = 1'b1;
        end
        else
        begin
            if (sym_seen[sym] && pos_of_sym[sym] >= win_start)
                win_start = {1'b0, pos_of_sym[sym]} + 17'd1;
            pos_of_sym[sym] = str_pos[15:0];
            sym_seen[sym]   = 1'b1;
            run_len = str_pos - win_start + 17'd1;
            if (run_len > best_run)
                best_run = run_len;
            str_pos = str_pos + 17'd1;
        end
        r.longest    = best_run;
        r.string_end = last;
        r.too_long   = over_limit;
        if (last)
        begin
            foreach (sym_seen[k])
                sym_seen[k] = 1'b0;
            win_start  = '0;
            str_pos    = '0;
            best_run   = '0;
            over_limit = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // one transfer on the input side, with a random gap in front of it
    task automatic send_symbol(input logic [lurt_pkg::SYMBOL_W-1:0] sym, input logic last,
                               input bit typed, input run_result_t typed_res);
        run_result_t r;
        int          gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        symbol      <= sym;
        last_symbol <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        r = advance_run_state(sym, last);
        pending_runs.push_back(typed ? typed_res : r);
    endtask

    task automatic send_random_strings(input int budget);
        int                            sent;
        int                            len;
        int                            span;
        logic [lurt_pkg::SYMBOL_W-1:0] base;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
            // narrow alphabets give frequent repeats and window moves
            case ($urandom_range(3))
                0: span = 2;
                1: span = 8;
                2: span = 40;
                default: span = 256;
            endcase
            base = lurt_pkg::SYMBOL_W'($urandom_range(255));
            for (int i = 0; i < len; i++)
            begin
                send_symbol(lurt_pkg::SYMBOL_W'(base + $urandom_range(span - 1)),
                            i == len - 1, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic drain_results;
        item_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
    endtask

    // output side: checks each transfer and picks the next stall
    initial
    begin
        run_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_runs.size() == 0)
                begin
                    flag_mismatch("result with nothing pending, longest_so_far",
                                  longest_so_far, 0);
                end
                else
                begin
                    want = pending_runs.pop_front();
                    if (longest_so_far !== want.longest)
                        flag_mismatch("longest_so_far", longest_so_far, want.longest);
                    if (string_end !== want.string_end)
                        flag_mismatch("string_end", string_end, want.string_end);
                    if (too_long !== want.too_long)
                        flag_mismatch("too_long", too_long, want.too_long);
                end
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_left = HOLD_CYCLES - 1;
                hold_req  = 1'b0;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        // single-byte string, repeats, clear between strings, window moves,
        // a stale entry behind the window start
        directed_rows = '{
            '{8'h00, 1'b1, 1'b1, 17'd1, 1'b0},
            '{8'hFF, 1'b0, 1'b1, 17'd1, 1'b0},
            '{8'hFF, 1'b0, 1'b1, 17'd1, 1'b0},
            '{8'h00, 1'b0, 1'b1, 17'd2, 1'b0},
            '{8'hFF, 1'b1, 1'b1, 17'd2, 1'b0},
            '{8'h61, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h63, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h61, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h63, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h62, 1'b1, 1'b1, 17'd3, 1'b0},
            '{8'h61, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h62, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h61, 1'b1, 1'b1, 17'd2, 1'b0},
            '{8'h64, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h76, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h64, 1'b0, 1'b0, 17'd0, 1'b0},
            '{8'h66, 1'b1, 1'b1, 17'd3, 1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 69;
        foreach (directed_rows[i])
            send_symbol(directed_rows[i].sym, directed_rows[i].last, directed_rows[i].typed,
                        '{directed_rows[i].want_len, directed_rows[i].last,
                          directed_rows[i].want_too_long});
        send_random_strings(360);
        drain_results();

        send_idle_pct = 69;
        recv_idle_pct = 38;
        send_random_strings(380);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // output held off while input keeps coming, so the block backs up
        hold_req = 1'b1;
        send_random_strings(390);
        drain_results();

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lurt_pkg.sv
rtl/lurt_sym_map.sv
rtl/lurt_seen_mem.sv
rtl/lurt_window.sv
rtl/longest_unique_run_tracker.sv
tb/tb_longest_unique_run_tracker.sv
